[hdl/ccl_pkg.sv]
// ----------------------------------------------------------------------------
// ccl_pkg
// Shared types, register indexes and helpers for the cache lookup block.
// ----------------------------------------------------------------------------
package ccl_pkg;

	// register indexes on the configuration port
	localparam logic [1:0] REG_ORGANISATION = 2'd0;
	localparam logic [1:0] REG_SET_BITS     = 2'd1;
	localparam logic [1:0] REG_WAYS         = 2'd2;

	// organisation codes
	localparam logic [1:0] ORG_DIRECT = 2'd0;
	localparam logic [1:0] ORG_FULL   = 2'd2;

	localparam logic [15:0] LFSR_SEED = 16'hACE1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_MOD,
		ST_UPDATE,
		ST_READ,
		ST_DONE
	} ccl_state_t;

	// request to the remainder unit
	typedef struct packed {
		logic        start;
		logic [15:0] dividend;
	} ccl_mod_req_t;

	// Fibonacci LFSR, taps 16,14,13,11
	function automatic logic [15:0] lfsr_next(input logic [15:0] s);
		logic fb;
		fb = s[0] ^ s[2] ^ s[3] ^ s[5];
		return {fb, s[15:1]};
	endfunction

endpackage

[hdl/ccl_ram.sv]
// ----------------------------------------------------------------------------
// ccl_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ccl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[hdl/ccl_mod.sv]
// ----------------------------------------------------------------------------
// ccl_mod
// Bit-serial remainder of a 16-bit value by the ways in use.
// ----------------------------------------------------------------------------
module ccl_mod #(
	parameter int CNT_W = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ccl_pkg::ccl_mod_req_t     req,
	input  logic [CNT_W-1:0]          divisor,
	output logic                      done,
	output logic [CNT_W-1:0]          remainder
);
	import ccl_pkg::*;

	logic [15:0]    dvd_q;
	logic [CNT_W:0] rem_q;
	logic [3:0]     cnt_q;
	logic           busy_q;
	logic [CNT_W:0] shifted;
	logic [CNT_W:0] next_rem;

	// one quotient digit per cycle
	always_comb begin
		shifted  = {rem_q[CNT_W-1:0], dvd_q[15]};
		next_rem = (shifted >= {1'b0, divisor}) ? shifted - {1'b0, divisor} : shifted;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[14:0], 1'b0};
			rem_q <= next_rem;
		end
	end

	assign remainder = rem_q[CNT_W-1:0];
endmodule

[hdl/configurable_cache_lookup_random_replace.sv]
// ----------------------------------------------------------------------------
// configurable_cache_lookup_random_replace
// Word cache lookup, direct mapped / set / fully associative, random victim.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake           Beat fields
// in       in   in_valid/in_stall   operation, address, write_data
// out      out  out_valid/out_stall read_data, hit, hits_so_far, misses_so_far
// cfg      in   cfg_write           cfg_index, cfg_data
//
// A write, a direct mapped miss or a miss into a set with room: the beat passes
// LOOKUP (the tag compare), UPDATE and DONE, from which the result is
// registered, and the next beat is taken back in IDLE. A read hit adds READ for
// the word RAM read; a miss into a full set adds MOD for the serial remainder of
// the LFSR. After reset a clearing pass zeroes the word RAM, one word a cycle,
// and the valid and fill fields of the tag rows, over all
// MAX_SETS*MAX_WAYS*2^OFFSET_BITS words (2048 by default); no beat is taken. A
// new beat is taken while a result waits; the next result holds until free.
// ----------------------------------------------------------------------------
module configurable_cache_lookup_random_replace #(
	parameter int MAX_SETS    = 64,
	parameter int MAX_WAYS    = 8,
	parameter int OFFSET_BITS = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [31:0] address,
	input  logic [31:0] write_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data,
	output logic        hit,
	output logic [31:0] hits_so_far,
	output logic [31:0] misses_so_far
);
	import ccl_pkg::*;

	localparam int SET_W     = $clog2(MAX_SETS > 1 ? MAX_SETS : 2);
	localparam int SB_MAX    = $clog2(MAX_SETS + 1) - 1;
	localparam int WAY_W     = $clog2(MAX_WAYS > 1 ? MAX_WAYS : 2);
	localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1);
	localparam int TAG_W     = 32 - OFFSET_BITS;
	localparam int WDEPTH    = MAX_SETS * MAX_WAYS * (1 << OFFSET_BITS);
	localparam int WADDR_W   = $clog2(WDEPTH > 1 ? WDEPTH : 2);
	// row layout: fill count, valid bits, tags
	localparam int VLD_LSB   = MAX_WAYS * TAG_W;
	localparam int FILL_LSB  = VLD_LSB + MAX_WAYS;
	localparam int ROW_W     = FILL_LSB + WAY_CNT_W;

	ccl_state_t state_q, state_d;

	logic [1:0] org_q;
	logic [2:0] sib_q;
	logic [3:0] wiu_q;

	logic [WAY_CNT_W-1:0] ways_eff;
	logic [2:0]           sb_eff;
	logic [31:0]          set_sel;
	logic [31:0]          tag_full;
	logic [SET_W-1:0]     in_set;

	logic                 op_q;
	logic [31:0]          addr_q;
	logic [31:0]          wdata_q;
	logic [SET_W-1:0]     set_q;
	logic [TAG_W-1:0]     tag_q;
	logic [WAY_W-1:0]     way_q;
	logic                 hit_q;
	logic                 fill_inc_q;
	logic [31:0]          res_q;
	logic [15:0]          lfsr_q;
	logic [31:0]          hits_q;
	logic [31:0]          misses_q;

	logic [ROW_W-1:0]     tag_rd;
	logic [ROW_W-1:0]     tag_wr;
	logic [ROW_W-1:0]     tag_wdata;
	logic [SET_W-1:0]     tag_waddr;
	logic                 tag_we;
	logic                 tag_re;

	logic                 wr_we;
	logic                 wr_re;
	logic [WADDR_W-1:0]   wr_waddr;
	logic [31:0]          wr_wdata;
	logic [31:0]          wr_rdata;
	logic [31:0]          word_idx;
	logic [WADDR_W-1:0]   clr_q;

	logic [MAX_WAYS-1:0]  hit_vec;
	logic                 any_hit;
	logic [WAY_W-1:0]     hit_way;
	logic [WAY_CNT_W-1:0] fill_cur;
	logic                 out_free;
	logic                 accept;

	ccl_mod_req_t         mod_req;
	logic                 mod_done;
	logic [WAY_CNT_W-1:0] mod_rem;

	// effective organisation
	always_comb begin
		if (org_q == ORG_DIRECT || wiu_q == 4'd0) begin
			ways_eff = WAY_CNT_W'(1);
		end else if (32'(wiu_q) > 32'(MAX_WAYS)) begin
			ways_eff = WAY_CNT_W'(MAX_WAYS);
		end else begin
			ways_eff = WAY_CNT_W'(wiu_q);
		end
		if (org_q == ORG_FULL) begin
			sb_eff = 3'd0;
		end else if (32'(sib_q) > 32'(SB_MAX)) begin
			sb_eff = 3'(SB_MAX);
		end else begin
			sb_eff = sib_q;
		end
	end

	// address split
	always_comb begin
		set_sel  = (address >> OFFSET_BITS) & ((32'd1 << sb_eff) - 32'd1);
		tag_full = address >> (OFFSET_BITS + 32'(sb_eff));
		in_set   = set_sel[SET_W-1:0];
	end

	// way compare, lowest hitting way wins
	always_comb begin
		hit_vec = '0;
		hit_way = '0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			hit_vec[w] = (32'(w) < 32'(ways_eff)) && tag_rd[VLD_LSB + w] &&
				(tag_rd[w*TAG_W +: TAG_W] == tag_q);
		end
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (hit_vec[w]) begin
				hit_way = WAY_W'(w);
			end
		end
		any_hit  = |hit_vec;
		fill_cur = tag_rd[FILL_LSB +: WAY_CNT_W];
	end

	// word index and tag row merge
	always_comb begin
		word_idx = (((32'(set_q) * 32'(MAX_WAYS)) + 32'(way_q)) << OFFSET_BITS) |
			(addr_q & ((32'd1 << OFFSET_BITS) - 32'd1));
		tag_wr = tag_rd;
		tag_wr[32'(way_q)*TAG_W +: TAG_W] = tag_q;
		tag_wr[VLD_LSB + 32'(way_q)] = 1'b1;
		if (fill_inc_q) begin
			tag_wr[FILL_LSB +: WAY_CNT_W] = tag_rd[FILL_LSB +: WAY_CNT_W] +
				WAY_CNT_W'(1);
		end
	end

	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// next state and control
	always_comb begin
		state_d          = state_q;
		tag_re           = 1'b0;
		tag_we           = 1'b0;
		tag_waddr        = set_q;
		tag_wdata        = tag_wr;
		wr_we            = 1'b0;
		wr_re            = 1'b0;
		wr_waddr         = word_idx[WADDR_W-1:0];
		wr_wdata         = op_q ? wdata_q : 32'd0;
		mod_req.start    = 1'b0;
		mod_req.dividend = lfsr_next(lfsr_q);
		case (state_q)
			ST_CLEAR: begin
				wr_we     = 1'b1;
				wr_waddr  = clr_q;
				wr_wdata  = 32'd0;
				tag_we    = (32'(clr_q) < MAX_SETS);
				tag_waddr = clr_q[SET_W-1:0];
				tag_wdata = '0;
				if (32'(clr_q) == WDEPTH - 1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				tag_re = accept;
				if (accept) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (any_hit || org_q == ORG_DIRECT || fill_cur < ways_eff) begin
					state_d = ST_UPDATE;
				end else begin
					mod_req.start = 1'b1;
					state_d       = ST_MOD;
				end
			end
			ST_MOD: begin
				if (mod_done) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (hit_q && !op_q) begin
					wr_re   = 1'b1;
					state_d = ST_READ;
				end else begin
					wr_we   = 1'b1;
					tag_we  = !hit_q;
					state_d = ST_DONE;
				end
			end
			ST_READ: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_q      <= ORG_DIRECT;
			sib_q      <= 3'd6;
			wiu_q      <= 4'd1;
			clr_q      <= '0;
			lfsr_q     <= LFSR_SEED;
			hits_q     <= '0;
			misses_q   <= '0;
			out_valid  <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_ORGANISATION: org_q <= cfg_data[1:0];
					REG_SET_BITS:     sib_q <= cfg_data[2:0];
					REG_WAYS:         wiu_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + WADDR_W'(1);
			end
			if (mod_req.start) begin
				lfsr_q <= mod_req.dividend;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid <= 1'b1;
				if (hit_q) begin
					hits_q <= hits_q + 32'd1;
				end else begin
					misses_q <= misses_q + 32'd1;
				end
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// access payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= operation;
			addr_q  <= address;
			wdata_q <= write_data;
			set_q   <= in_set;
			tag_q   <= tag_full[TAG_W-1:0];
		end
		if (state_q == ST_LOOKUP) begin
			hit_q      <= any_hit;
			fill_inc_q <= !any_hit && org_q != ORG_DIRECT && fill_cur < ways_eff;
			if (any_hit) begin
				way_q <= hit_way;
			end else if (org_q == ORG_DIRECT) begin
				way_q <= '0;
			end else if (fill_cur < ways_eff) begin
				way_q <= fill_cur[WAY_W-1:0];
			end
		end
		if (state_q == ST_MOD && mod_done) begin
			way_q <= mod_rem[WAY_W-1:0];
		end
		if (state_q == ST_UPDATE) begin
			res_q <= op_q ? wdata_q : 32'd0;
		end
		if (state_q == ST_READ) begin
			res_q <= wr_rdata;
		end
		if (state_q == ST_DONE && out_free) begin
			read_data     <= res_q;
			hit           <= hit_q;
			hits_so_far   <= hit_q ? hits_q + 32'd1 : hits_q;
			misses_so_far <= hit_q ? misses_q : misses_q + 32'd1;
		end
	end

	// tag rows with valid bits and fill count, one per set
	ccl_ram #(
		.WIDTH(ROW_W),
		.DEPTH(MAX_SETS)
	) u_tag_ram (
		.clk  (clk),
		.we   (tag_we),
		.waddr(tag_waddr),
		.wdata(tag_wdata),
		.re   (tag_re),
		.raddr(in_set),
		.rdata(tag_rd)
	);

	// line words
	ccl_ram #(
		.WIDTH(32),
		.DEPTH(WDEPTH)
	) u_word_ram (
		.clk  (clk),
		.we   (wr_we),
		.waddr(wr_waddr),
		.wdata(wr_wdata),
		.re   (wr_re),
		.raddr(word_idx[WADDR_W-1:0]),
		.rdata(wr_rdata)
	);

	// victim pick
	ccl_mod #(
		.CNT_W(WAY_CNT_W)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (mod_req),
		.divisor  (ways_eff),
		.done     (mod_done),
		.remainder(mod_rem)
	);
endmodule

[test/tb_configurable_cache_lookup_random_replace.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_configurable_cache_lookup_random_replace
// Drives read and write accesses under several cache organisations and checks
// every result beat against a behavioral cache model kept in the testbench.
// ----------------------------------------------------------------------------
module tb_configurable_cache_lookup_random_replace;
	import ccl_pkg::*;

	localparam int N_SETS  = 64;
	localparam int N_WAYS  = 8;
	localparam int OFF_W   = 2;
	localparam int N_LINES = N_SETS * N_WAYS;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;
	localparam logic [1:0] ORG_SET = 2'd1;
	localparam logic [1:0] ORG_ODD = 2'd3;

	typedef struct packed {
		logic [31:0] read_data;
		logic        hit;
		logic [31:0] hits;
		logic [31:0] misses;
	} access_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic [1:0]  cfg_index;
	logic [3:0]  cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        operation;
	logic [31:0] address;
	logic [31:0] write_data;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] read_data;
	logic        hit;
	logic [31:0] hits_so_far;
	logic [31:0] misses_so_far;

	// model state
	logic [1:0]  m_org;
	logic [2:0]  m_sbits;
	logic [3:0]  m_ways;
	logic [31:0] m_tag   [N_LINES];
	logic        m_valid [N_LINES];
	logic [31:0] m_words [N_LINES * 4];
	logic [3:0]  m_fill  [N_SETS];
	logic [15:0] m_lfsr;
	logic [31:0] m_hits, m_misses;

	access_result_t pending_results[$];
	int  errors;
	bit  quiet_out;
	bit  calm;
	int  tag_pool;

	configurable_cache_lookup_random_replace DUT (.*);

	always #5 clk = ~clk;

	// predicted outcome of one access; updates model state
	function automatic access_result_t cache_access(logic op, logic [31:0] a,
			logic [31:0] wd);
		access_result_t r;
		int ways, sb, set, off, line, w, hw, widx;
		logic [31:0] tg;
		logic fb;
		ways = (m_ways == 4'd0) ? 1 : ((int'(m_ways) > N_WAYS) ? N_WAYS : int'(m_ways));
		if (m_org == ORG_DIRECT) ways = 1;
		sb = (m_org == ORG_FULL) ? 0 : int'(m_sbits);
		while (sb > 0 && (1 << sb) > N_SETS) sb--;
		off = int'(a[OFF_W-1:0]);
		set = int'((a >> OFF_W) & ((32'd1 << sb) - 32'd1));
		tg = a >> (OFF_W + sb);
		hw = -1;
		for (w = 0; w < ways; w++) begin
			line = set * N_WAYS + w;
			if (hw < 0 && m_valid[line] && m_tag[line] == tg) hw = w;
		end
		if (hw >= 0) begin
			widx = (set * N_WAYS + hw) * 4 + off;
			if (op == OP_WRITE) m_words[widx] = wd;
			m_hits++;
		end else begin
			m_misses++;
			if (m_org == ORG_DIRECT) w = 0;
			else if (int'(m_fill[set]) < ways) begin
				w = int'(m_fill[set]);
				m_fill[set]++;
			end else begin
				fb = m_lfsr[0] ^ m_lfsr[2] ^ m_lfsr[3] ^ m_lfsr[5];
				m_lfsr = {fb, m_lfsr[15:1]};
				w = int'(m_lfsr) % ways;
			end
			line = set * N_WAYS + w;
			m_valid[line] = 1'b1;
			m_tag[line] = tg;
			widx = line * 4 + off;
			m_words[widx] = (op == OP_WRITE) ? wd : 32'd0;
		end
		r.read_data = m_words[widx];
		r.hit = (hw >= 0);
		r.hits = m_hits;
		r.misses = m_misses;
		return r;
	endfunction

	// send one access beat
	task automatic send_access(logic op, logic [31:0] a, logic [31:0] wd);
		while (!calm && $urandom_range(99) < 25) @(negedge clk);
		in_valid   = 1'b1;
		operation  = op;
		address    = a;
		write_data = wd;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.push_back(cache_access(op, a, wd));
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic drain();
		while (pending_results.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [3:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		case (idx)
			REG_ORGANISATION: m_org   = val[1:0];
			REG_SET_BITS:     m_sbits = val[2:0];
			REG_WAYS:         m_ways  = val;
			default: ;
		endcase
	endtask

	task automatic set_config(logic [1:0] org, logic [3:0] sb, logic [3:0] ways);
		drain();
		write_reg(REG_ORGANISATION, {2'b00, org});
		write_reg(REG_SET_BITS, sb);
		write_reg(REG_WAYS, ways);
		cfg_write <= 1'b0;
	endtask

	// address drawn from a small tag pool so that hits and full sets occur
	function automatic logic [31:0] pick_address();
		logic [31:0] a;
		a = $urandom;
		if ($urandom_range(9) != 0) a[31:24] = 8'($urandom_range(tag_pool));
		if ($urandom_range(9) != 0) a[31:12] = 20'($urandom_range(tag_pool));
		return a;
	endfunction

	task automatic test_reset_config();
		send_access(OP_READ, 32'h0, 32'h0);
		send_access(OP_WRITE, 32'h0, 32'hFFFF_FFFF);
		send_access(OP_READ, 32'h0, 32'h0);
		send_access(OP_WRITE, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
		send_access(OP_READ, 32'hFFFF_FFFF, 32'h0);
		send_access(OP_READ, 32'hFFFF_FF00, 32'h0);
		send_access(OP_WRITE, 32'h0000_0100, 32'h1234_5678);
		send_access(OP_READ, 32'h0000_0000, 32'h0);
	endtask

	task automatic test_full_set_victims();
		// fully associative, eight ways: fill then force LFSR replacements
		set_config(ORG_FULL, 4'd7, 4'd8);
		for (int i = 0; i < 12; i++)
			send_access(i[0] ? OP_WRITE : OP_READ, 32'(i << 6), $urandom);
		// lower the ways below the fill count: set counts as full
		set_config(ORG_SET, 4'd0, 4'd3);
		send_access(OP_READ, 32'h0000_1000, 32'h0);
		send_access(OP_READ, 32'h0000_0040, 32'h0);
		// odd codes: organisation three, ways zero and above the max
		set_config(ORG_ODD, 4'd1, 4'd0);
		send_access(OP_WRITE, 32'h4, 32'h0BAD_F00D);
		send_access(OP_READ, 32'h4, 32'h0);
		set_config(ORG_SET, 4'd2, 4'd15);
		send_access(OP_WRITE, 32'h8000_0008, 32'h5555_AAAA);
		send_access(OP_READ, 32'h8000_0008, 32'h0);
	endtask

	task automatic test_random_mix(int n, int pool);
		tag_pool = pool;
		for (int i = 0; i < n; i++)
			send_access(1'($urandom_range(1)), pick_address(), $urandom);
	endtask

	task automatic test_random_configs();
		for (int p = 0; p < 8; p++) begin
			set_config(2'($urandom_range(3)), 4'($urandom_range(15)),
				4'($urandom_range(15)));
			calm = (p == 3);
			test_random_mix(60, $urandom_range(1, 12));
		end
		calm = 0;
		set_config(ORG_DIRECT, 4'd0, 4'd1);
		test_random_mix(50, 4);
		set_config(ORG_SET, 4'd6, 4'd8);
		test_random_mix(50, 3);
		set_config(ORG_FULL, 4'd0, 4'd8);
		test_random_mix(50, 20);
	endtask

	// result checker
	always @(posedge clk) begin
		access_result_t e;
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result beat");
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (read_data !== e.read_data) begin
					$error("read_data exp %h got %h", e.read_data, read_data);
					errors++;
				end
				if (hit !== e.hit) begin
					$error("hit exp %b got %b", e.hit, hit);
					errors++;
				end
				if (hits_so_far !== e.hits) begin
					$error("hits_so_far exp %0d got %0d", e.hits, hits_so_far);
					errors++;
				end
				if (misses_so_far !== e.misses) begin
					$error("misses_so_far exp %0d got %0d", e.misses, misses_so_far);
					errors++;
				end
			end
		end
	end

	// receiver stall, none during the calm stretch
	always @(negedge clk)
		out_stall <= (quiet_out || calm) ? 1'b0 : ($urandom_range(99) < 25);

	initial begin
		#20_000_000;
		$display("configurable_cache_lookup_random_replace: mismatch");
		$finish;
	end

	initial begin
		clk = 0; arst_n = 0; cfg_write = 0; cfg_index = REG_ORGANISATION; cfg_data = 0;
		in_valid = 0; operation = OP_READ; address = 0; write_data = 0; out_stall = 0;
		errors = 0; quiet_out = 0; calm = 0; tag_pool = 4;
		m_org = ORG_DIRECT; m_sbits = 3'd6; m_ways = 4'd1;
		m_lfsr = LFSR_SEED; m_hits = 0; m_misses = 0;
		for (int i = 0; i < N_LINES; i++) begin
			m_valid[i] = 0;
			m_tag[i] = 0;
		end
		for (int i = 0; i < N_LINES * 4; i++) m_words[i] = 0;
		for (int i = 0; i < N_SETS; i++) m_fill[i] = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_config();
		test_full_set_victims();
		test_random_configs();

		quiet_out = 1;
		drain();
		if (errors == 0)
			$display("configurable_cache_lookup_random_replace: match");
		else
			$display("configurable_cache_lookup_random_replace: mismatch");
		$finish;
	end

endmodule

[sim.f]
hdl/ccl_pkg.sv
hdl/ccl_ram.sv
hdl/ccl_mod.sv
hdl/configurable_cache_lookup_random_replace.sv
test/tb_configurable_cache_lookup_random_replace.sv
